>>> rtl/core/button_tap_classifier_unit_defines.svh
// assertion macros for the button tap classifier
// used by the top level only, no other dependencies
`ifndef BUTTON_TAP_CLASSIFIER_UNIT_DEFINES_SVH
`define BUTTON_TAP_CLASSIFIER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BTC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("btc assertion failed");
`define BTC_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("btc reset assertion failed");
`else
`define BTC_ASSERT(label, clk, rst_n, prop)
`define BTC_ASSERT_RST(label, clk, prop)
`endif

`endif

>>> rtl/core/btc_pkg.sv
// shared types and constants for the button tap classifier
// no dependencies
package btc_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int STAMP_W = 32;
  localparam int THR_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_PRESSED  = 2'd1;
  localparam logic [1:0] PH_RELEASED = 2'd2;
  localparam logic [1:0] PH_LONG     = 2'd3;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_SINGLE = 2'd1;
  localparam logic [1:0] KIND_DOUBLE = 2'd2;
  localparam logic [1:0] KIND_LONG   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_GAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_EXTRA = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT      = 2'd3;

  localparam logic [THR_W-1:0] LONG_PRESS_RST   = 16'd2000;
  localparam logic [THR_W-1:0] DOUBLE_GAP_RST   = 16'd400;
  localparam logic [THR_W-1:0] SETTLE_EXTRA_RST = 16'd500;

  typedef struct packed {
    logic [THR_W-1:0] long_press_ms;
    logic [THR_W-1:0] double_gap_ms;
    logic [THR_W-1:0] settle_extra_ms;
    logic             device_present;
  } cfg_t;

  typedef struct packed {
    logic [STAMP_W-1:0] time_ms;
    logic               button_latch;
  } poll_t;

  typedef struct packed {
    logic [1:0] tap_kind;
    logic       clear_latch;
  } res_t;

endpackage

>>> rtl/core/button_tap_classifier_unit.sv
// button tap classifier: single, double and long press detection per poll
// channels: in (time_ms, button_latch), out (tap_kind, clear_latch), each
//   with valid and stall; cfg write port with valid, ready, index and data
// every accepted poll yields exactly one request on the output channel
// path: an accepted poll goes through the input register, then the result
//   register, and it waits in the input register while out_stall holds a result;
//   throughput one poll per clock while out_stall is low, set by the single
//   classification pass between the two registers
// cfg_ready is always high; register 0 long press time, 1 double tap gap,
//   2 settle time after a long press, 3 device present (bit 0)
// reset (synchronous, rst_n low) empties both registers, returns the press
//   state to idle with zero stamps and loads the default thresholds
// when out_stall holds a waiting result, one more poll is still taken into
//   the input register; after that in_stall rises until the result is taken
// depends on btc_pkg, btc_cfg, btc_in_stage, btc_fsm, btc_out_stage and the defines header
`include "button_tap_classifier_unit_defines.svh"
module button_tap_classifier_unit #(
  parameter int TIME_BITS = btc_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [btc_pkg::STAMP_W-1:0]   in_time_ms,
  input  logic                          in_button_latch,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_tap_kind,
  output logic                          out_clear_latch,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [btc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [btc_pkg::THR_W-1:0]     cfg_wdata
);
  import btc_pkg::*;

  cfg_t       cfg;
  poll_t      in_item;
  poll_t      s1_item;
  res_t       result;
  res_t       out_result;
  logic       s1_valid;
  logic       free;
  logic       fire;
  logic [1:0] phase;
  logic       out_none;

  assign cfg_ready = 1'b1;
  assign in_item.time_ms = in_time_ms;
  assign in_item.button_latch = in_button_latch;
  assign fire = s1_valid & free;

  btc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  btc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (free),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  btc_fsm #(
    .TIME_BITS (TIME_BITS)
  ) u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_item),
    .cfg    (cfg),
    .result (result),
    .phase  (phase)
  );

  btc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .result     (result),
    .free       (free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign out_tap_kind = out_result.tap_kind;
  assign out_clear_latch = out_result.clear_latch;

  // result register holds an empty request
  assign out_none = (out_tap_kind == KIND_NONE) && !out_clear_latch;

  `BTC_ASSERT(a_absent_none, clk, rst_n, (fire && !cfg.device_present) |=> (out_valid && out_none))
  `BTC_ASSERT(a_idle_none, clk, rst_n, (fire && phase == PH_IDLE) |=> (out_tap_kind == KIND_NONE))
  `BTC_ASSERT(a_held_item, clk, rst_n, (s1_valid && !free) |=> (s1_valid && $stable(s1_item)))
  `BTC_ASSERT_RST(a_reset_empty, clk, !rst_n |=> (!out_valid && !s1_valid))

endmodule

>>> rtl/core/btc_cfg.sv
// configuration registers of the button tap classifier
// depends on btc_pkg
module btc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [btc_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [btc_pkg::THR_W-1:0]     wr_data,
  output btc_pkg::cfg_t                 cfg
);
  import btc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_LONG_PRESS:   cfg_nxt.long_press_ms   = wr_data;
        CFG_DOUBLE_GAP:   cfg_nxt.double_gap_ms   = wr_data;
        CFG_SETTLE_EXTRA: cfg_nxt.settle_extra_ms = wr_data;
        CFG_PRESENT:      cfg_nxt.device_present  = wr_data[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ms   <= LONG_PRESS_RST;
      cfg_r.double_gap_ms   <= DOUBLE_GAP_RST;
      cfg_r.settle_extra_ms <= SETTLE_EXTRA_RST;
      cfg_r.device_present  <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/btc_in_stage.sv
// input register of the button tap classifier
// depends on btc_pkg
module btc_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  btc_pkg::poll_t in_item,
  input  logic           advance,
  output logic           s1_valid,
  output btc_pkg::poll_t s1_item
);
  import btc_pkg::*;

  logic  s1_valid_r;
  logic  s1_valid_nxt;
  poll_t s1_item_r;
  logic  take;

  assign in_stall = s1_valid_r & ~advance;
  assign take = in_valid & ~in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item = s1_item_r;

endmodule

>>> rtl/core/btc_fsm.sv
// press state machine and poll classification
// depends on btc_pkg
module btc_fsm #(
  parameter int TIME_BITS = btc_pkg::TIME_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  btc_pkg::poll_t item,
  input  btc_pkg::cfg_t  cfg,
  output btc_pkg::res_t  result,
  output logic [1:0]     phase
);
  import btc_pkg::*;

  localparam int SUM_W = THR_W + 1;
  localparam int CMP_W = (TIME_BITS > SUM_W) ? TIME_BITS : SUM_W;

  logic [1:0]           phase_r;
  logic [1:0]           phase_nxt;
  logic [TIME_BITS-1:0] press_r;
  logic [TIME_BITS-1:0] press_nxt;
  logic [TIME_BITS-1:0] release_r;
  logic [TIME_BITS-1:0] release_nxt;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] d_press;
  logic [TIME_BITS-1:0] d_release;
  logic [SUM_W-1:0]     settle_lim;
  logic                 press_long;
  logic                 gap_ok;
  logic                 settled;
  logic                 ev;
  logic [1:0]           kind;

  assign now        = TIME_BITS'(item.time_ms);
  assign ev         = item.button_latch;
  assign d_press    = now - press_r;
  assign d_release  = now - release_r;
  assign settle_lim = SUM_W'(cfg.long_press_ms) + SUM_W'(cfg.settle_extra_ms);
  assign press_long = CMP_W'(d_press) >= CMP_W'(cfg.long_press_ms);
  assign gap_ok     = CMP_W'(d_release) <= CMP_W'(cfg.double_gap_ms);
  assign settled    = CMP_W'(d_press) > CMP_W'(settle_lim);

  always_comb begin
    phase_nxt   = phase_r;
    press_nxt   = press_r;
    release_nxt = release_r;
    kind        = KIND_NONE;
    case (phase_r)
      PH_IDLE: begin
        if (ev) begin
          press_nxt = now;
          phase_nxt = PH_PRESSED;
        end
      end
      PH_PRESSED: begin
        if (ev) begin
          if (press_long) begin
            kind      = KIND_LONG;
            phase_nxt = PH_LONG;
          end
        end else if (!press_long) begin
          release_nxt = now;
          phase_nxt   = PH_RELEASED;
        end else begin
          kind      = KIND_LONG;
          phase_nxt = PH_IDLE;
        end
      end
      PH_RELEASED: begin
        if (ev) begin
          if (gap_ok) begin
            kind      = KIND_DOUBLE;
            phase_nxt = PH_IDLE;
          end else begin
            kind      = KIND_SINGLE;
            press_nxt = now;
            phase_nxt = PH_PRESSED;
          end
        end else if (!gap_ok) begin
          kind      = KIND_SINGLE;
          phase_nxt = PH_IDLE;
        end
      end
      PH_LONG: begin
        if (ev) begin
          press_nxt = now;
        end else if (settled) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // absent device: result none, state held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      press_r   <= '0;
      release_r <= '0;
    end else if (fire && cfg.device_present) begin
      phase_r   <= phase_nxt;
      press_r   <= press_nxt;
      release_r <= release_nxt;
    end
  end

  assign result.tap_kind    = cfg.device_present ? kind : KIND_NONE;
  assign result.clear_latch = cfg.device_present & ev;
  assign phase = phase_r;

endmodule

>>> rtl/core/btc_out_stage.sv
// result register of the button tap classifier
// depends on btc_pkg
module btc_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  btc_pkg::res_t result,
  output logic          free,
  output logic          out_valid,
  input  logic          out_stall,
  output btc_pkg::res_t out_result
);
  import btc_pkg::*;

  logic out_valid_r;
  logic out_valid_nxt;
  res_t out_result_r;

  assign free = ~out_valid_r | ~out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_result_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_result = out_result_r;

endmodule

>>> tb/sv/button_tap_classifier_unit_test.sv
// testbench for button_tap_classifier_unit: directed and random poll requests,
// each tap result checked against a tap classifier predictor kept in a scoreboard class
// depends on btc_pkg and the button_tap_classifier_unit rtl
`timescale 1ns / 100ps

module button_tap_classifier_unit_test;
  import btc_pkg::*;

  class tap_scoreboard;
    logic [THR_W-1:0]   long_press_ms;
    logic [THR_W-1:0]   double_gap_ms;
    logic [THR_W-1:0]   settle_extra_ms;
    logic               device_present;
    logic [1:0]         tap_phase;
    logic [STAMP_W-1:0] press_stamp;
    logic [STAMP_W-1:0] release_stamp;
    res_t               pending_taps[$];
    int unsigned        errors;

    function new();
      long_press_ms   = LONG_PRESS_RST;
      double_gap_ms   = DOUBLE_GAP_RST;
      settle_extra_ms = SETTLE_EXTRA_RST;
      device_present  = 1'b1;
      tap_phase       = PH_IDLE;
      press_stamp     = '0;
      release_stamp   = '0;
      errors          = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] val);
      case (idx)
        CFG_LONG_PRESS:   long_press_ms = val;
        CFG_DOUBLE_GAP:   double_gap_ms = val;
        CFG_SETTLE_EXTRA: settle_extra_ms = val;
        CFG_PRESENT:      device_present = val[0];
        default: ;
      endcase
    endfunction

    function void classify_poll(logic [STAMP_W-1:0] now, logic latch);
      res_t             tap;
      logic [STAMP_W-1:0] since_press;
      logic [STAMP_W-1:0] since_release;
      logic [THR_W:0]     settle_total;
      tap.tap_kind    = KIND_NONE;
      tap.clear_latch = 1'b0;
      if (device_present) begin
        since_press     = now - press_stamp;
        since_release   = now - release_stamp;
        settle_total    = {1'b0, long_press_ms} + {1'b0, settle_extra_ms};
        tap.clear_latch = latch;
        case (tap_phase)
          PH_IDLE: begin
            if (latch) begin
              press_stamp = now;
              tap_phase   = PH_PRESSED;
            end
          end
          PH_PRESSED: begin
            if (latch) begin
              if (since_press >= long_press_ms) begin
                tap.tap_kind = KIND_LONG;
                tap_phase    = PH_LONG;
              end
            end else if (since_press < long_press_ms) begin
              release_stamp = now;
              tap_phase     = PH_RELEASED;
            end else begin
              tap.tap_kind = KIND_LONG;
              tap_phase    = PH_IDLE;
            end
          end
          PH_RELEASED: begin
            if (latch) begin
              if (since_release <= double_gap_ms) begin
                tap.tap_kind = KIND_DOUBLE;
                tap_phase    = PH_IDLE;
              end else begin
                tap.tap_kind = KIND_SINGLE;
                press_stamp  = now;
                tap_phase    = PH_PRESSED;
              end
            end else if (since_release > double_gap_ms) begin
              tap.tap_kind = KIND_SINGLE;
              tap_phase    = PH_IDLE;
            end
          end
          default: begin
            if (latch) begin
              press_stamp = now;
            end else if (since_press > settle_total) begin
              tap_phase = PH_IDLE;
            end
          end
        endcase
      end
      pending_taps.push_back(tap);
    endfunction

    function void check_tap(logic [1:0] kind, logic clear);
      res_t want;
      if (pending_taps.size() == 0) begin
        $error("unexpected tap result: tap_kind %0d clear_latch %0b", kind, clear);
        errors++;
        return;
      end
      want = pending_taps.pop_front();
      if (kind !== want.tap_kind) begin
        $error("tap_kind: expected %0d, actual %0d", want.tap_kind, kind);
        errors++;
      end
      if (clear !== want.clear_latch) begin
        $error("clear_latch: expected %0b, actual %0b", want.clear_latch, clear);
        errors++;
      end
    endfunction

    function int pending();
      return pending_taps.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [STAMP_W-1:0]   in_time_ms = '0;
  logic                 in_button_latch = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_tap_kind;
  logic                 out_clear_latch;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [THR_W-1:0]     cfg_wdata = '0;

  tap_scoreboard      taps = new();
  int unsigned        send_idle_pct = 0;
  int unsigned        stall_pct = 0;
  int unsigned        polls_sent = 0;
  logic [STAMP_W-1:0] clock_ms = '0;

  button_tap_classifier_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_time_ms      (in_time_ms),
    .in_button_latch (in_button_latch),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_tap_kind    (out_tap_kind),
    .out_clear_latch (out_clear_latch),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      taps.check_tap(out_tap_kind, out_clear_latch);
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_poll(input logic [STAMP_W-1:0] t, input logic latch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_time_ms      <= t;
    in_button_latch <= latch;
    do @(posedge clk); while (in_stall);
    taps.classify_poll(t, latch);
    polls_sent++;
  endtask

  task automatic poll_at(input logic [STAMP_W-1:0] delta, input logic latch);
    clock_ms = clock_ms + delta;
    send_poll(clock_ms, latch);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (taps.pending() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    taps.write_reg(idx, val);
  endtask

  task automatic apply_settings(input logic [THR_W-1:0] lp, input logic [THR_W-1:0] dg,
                                input logic [THR_W-1:0] se, input logic [THR_W-1:0] pres);
    hold_until_drained();
    repeat (3) @(posedge clk);
    write_reg(CFG_LONG_PRESS, lp);
    write_reg(CFG_DOUBLE_GAP, dg);
    write_reg(CFG_SETTLE_EXTRA, se);
    write_reg(CFG_PRESENT, pres);
    cfg_valid <= 1'b0;
  endtask

  // delta close to a threshold, or anywhere up to it
  function automatic logic [STAMP_W-1:0] near(input logic [STAMP_W-1:0] lim);
    case ($urandom_range(3))
      0:       near = (lim == 0) ? '0 : lim - 1;
      1:       near = lim;
      2:       near = lim + 1;
      default: near = $urandom_range(lim);
    endcase
  endfunction

  task automatic run_gesture();
    logic [STAMP_W-1:0] lp;
    logic [STAMP_W-1:0] dg;
    logic [STAMP_W-1:0] se;
    lp = STAMP_W'(taps.long_press_ms);
    dg = STAMP_W'(taps.double_gap_ms);
    se = STAMP_W'(taps.settle_extra_ms);
    case ($urandom_range(9))
      0, 1, 2: begin
        // press, optional hold, release, then two quiet polls near or below the gap
        poll_at($urandom_range(3000), 1'b1);
        repeat ($urandom_range(2)) poll_at($urandom_range(lp / 4), 1'b1);
        poll_at(near(lp / 2), 1'b0);
        poll_at(near(dg), 1'b0);
        poll_at(near(dg), 1'b0);
      end
      3, 4: begin
        poll_at($urandom_range(3000), 1'b1);
        poll_at(near(lp / 2), 1'b0);
        poll_at(near(dg), 1'b1);
        poll_at($urandom_range(dg), 1'b0);
      end
      5, 6: begin
        poll_at($urandom_range(3000), 1'b1);
        poll_at(near(lp), 1'($urandom_range(1)));
        poll_at(near(lp + se), 1'($urandom_range(1)));
        poll_at(near(lp + se), 1'b0);
      end
      7: begin
        // noise, including jumps that wrap or go backwards
        repeat ($urandom_range(1, 4)) begin
          poll_at($urandom_range(1) ? $urandom : near(dg), 1'($urandom_range(1)));
        end
      end
      default: begin
        repeat ($urandom_range(1, 3)) poll_at($urandom_range(5000), 1'b0);
      end
    endcase
  endtask

  task automatic run_phase(input int unsigned n);
    int unsigned goal;
    goal = polls_sent + n;
    while (polls_sent < goal) begin
      if ($urandom_range(39) == 0) hold_until_drained();
      run_gesture();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 28;
    stall_pct     = 74;

    // default thresholds: taps at the gap boundary, long press, settle, wrap
    send_poll(32'd0, 1'b0);
    send_poll(32'd100, 1'b1);
    send_poll(32'd101, 1'b1);
    send_poll(32'd150, 1'b0);
    send_poll(32'd550, 1'b0);
    send_poll(32'd551, 1'b0);
    send_poll(32'd1000, 1'b1);
    send_poll(32'd1100, 1'b0);
    send_poll(32'd1500, 1'b1);
    send_poll(32'd3000, 1'b1);
    send_poll(32'd5000, 1'b1);
    send_poll(32'd5001, 1'b1);
    send_poll(32'd7501, 1'b0);
    send_poll(32'd7502, 1'b0);
    send_poll(32'd8000, 1'b1);
    send_poll(32'd9999, 1'b0);
    send_poll(32'd10800, 1'b1);
    send_poll(32'd12800, 1'b0);
    send_poll(32'hFFFF_FFF0, 1'b1);
    send_poll(32'h0000_0010, 1'b0);
    send_poll(32'h0000_0005, 1'b1);
    send_poll(32'hFFFF_FFFF, 1'b0);

    clock_ms = $urandom;
    run_phase(115);
    apply_settings(16'd1, 16'd1, 16'd0, 16'h0001);
    run_phase(110);

    send_idle_pct = 74;
    stall_pct     = 28;
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(110);
    apply_settings(16'd0, 16'd0, 16'd0, 16'h0003);
    run_phase(110);

    send_idle_pct = 0;
    stall_pct     = 0;
    // device absent, written with upper bits set
    apply_settings(LONG_PRESS_RST, DOUBLE_GAP_RST, SETTLE_EXTRA_RST, 16'hFFFE);
    run_phase(40);
    apply_settings(16'd20, 16'd8, 16'd5, 16'h0001);
    run_phase(110);
    apply_settings(THR_W'($urandom_range(1, 3000)), THR_W'($urandom_range(1, 800)),
                   THR_W'($urandom_range(0, 1000)), 16'h0001);
    run_phase(110);

    hold_until_drained();
    repeat (10) @(posedge clk);
    if (taps.errors == 0 && taps.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
